### design/ucer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucer_pkg
// shared types, request codes and descriptor table for the ep0 responder
// ----------------------------------------------------------------------------
package ucer_pkg;

    typedef enum logic [1:0] {
        CMD_SETUP   = 2'd0,
        CMD_IN_DONE = 2'd1,
        CMD_BUS_RST = 2'd2,
        CMD_SUSPEND = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        HS_ACK      = 2'd0,
        HS_NAK_TX   = 2'd1,
        HS_STALL    = 2'd2,
        HS_NOCHANGE = 2'd3
    } hs_t;

    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_GET_IFACE     = 8'h0a;
    localparam logic [7:0] CLS_SET_REPORT    = 8'h09;
    localparam logic [7:0] CLS_SET_IDLE      = 8'h0a;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam logic [4:0] RCPT_ENDPOINT = 5'd2;

    localparam logic [7:0] EP1_IN  = 8'h81;
    localparam logic [7:0] EP1_OUT = 8'h01;
    localparam logic [7:0] EP2_IN  = 8'h82;
    localparam logic [7:0] EP2_OUT = 8'h02;

    localparam logic [7:0] EPB_RESET = 8'hAA;

    localparam logic [7:0] OFS_DEV   = 8'd0;
    localparam logic [7:0] OFS_CFG   = 8'd18;
    localparam logic [7:0] OFS_LANG  = 8'd100;
    localparam logic [7:0] OFS_MANU  = 8'd104;
    localparam logic [7:0] OFS_PROD  = 8'd118;
    localparam logic [7:0] OFS_KEY   = 8'd128;
    localparam logic [7:0] OFS_MOUSE = 8'd190;

    localparam logic [15:0] LEN_DEV   = 16'd18;
    localparam logic [15:0] LEN_CFG   = 16'd82;
    localparam logic [15:0] LEN_LANG  = 16'd4;
    localparam logic [15:0] LEN_MANU  = 16'd14;
    localparam logic [15:0] LEN_PROD  = 16'd10;
    localparam logic [15:0] LEN_KEY   = 16'd62;
    localparam logic [15:0] LEN_MOUSE = 16'd52;

    localparam int          DESC_LEN     = 242;
    localparam logic [9:0]  PKT_SIZE_POS = 10'd7;

    // byte at the packet size position is patched by the core
    localparam logic [7:0] DESC_ROM [0:DESC_LEN-1] = '{
        8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h4A, 8'h43, 8'h40, 8'h55, 8'h01, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01,
        8'h09, 8'h02, 8'h52, 8'h00, 8'h03, 8'h01, 8'h00, 8'h80, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
        8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h3e, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A,
        8'h09, 8'h04, 8'h01, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
        8'h09, 8'h21, 8'h10, 8'h01, 8'h00, 8'h01, 8'h22, 8'h34, 8'h00,
        8'h07, 8'h05, 8'h82, 8'h03, 8'h04, 8'h00, 8'h0A,
        8'h09, 8'h04, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h83, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h03, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h04, 8'h03, 8'h09, 8'h04,
        8'h0E, 8'h03, 8'h6c, 8'h00, 8'h61, 8'h00, 8'h62, 8'h00, 8'h34, 8'h00,
        8'h31, 8'h00, 8'h38, 8'h00,
        8'h0A, 8'h03, 8'h54, 8'h00, 8'h50, 8'h00, 8'h37, 8'h00, 8'h38, 8'h00,
        8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'he0,
        8'h29, 8'he7, 8'h15, 8'h00, 8'h25,
        8'h01, 8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h95, 8'h01, 8'h75,
        8'h08, 8'h81, 8'h01, 8'h95, 8'h03,
        8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h03, 8'h91, 8'h02,
        8'h95, 8'h05, 8'h75, 8'h01, 8'h91,
        8'h01, 8'h95, 8'h06, 8'h75, 8'h08, 8'h26, 8'hff, 8'h00, 8'h05, 8'h07,
        8'h19, 8'h00, 8'h29, 8'h91, 8'h81,
        8'h00, 8'hC0,
        8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00,
        8'h05, 8'h09, 8'h19, 8'h01, 8'h29,
        8'h03, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h03, 8'h81,
        8'h02, 8'h75, 8'h05, 8'h95, 8'h01,
        8'h81, 8'h01, 8'h05, 8'h01, 8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h38,
        8'h15, 8'h81, 8'h25, 8'h7f, 8'h75,
        8'h08, 8'h95, 8'h03, 8'h81, 8'h06, 8'hC0, 8'hC0
    };

    function automatic logic [7:0] desc_byte(input logic [9:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 10'(DESC_LEN))
        begin
            b = DESC_ROM[idx[7:0]];
        end
        return b;
    endfunction

endpackage

### design/usb_control_endpoint_responder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder_core
// endpoint 0 control responder with a fixed descriptor rom
// ----------------------------------------------------------------------------
// s_axis carries one ep0 event per transaction: setup packet, in token done,
// bus reset or suspend change (kind in s_axis_tuser). m_axis returns the
// results of that event: one transaction per payload byte, or a single
// transaction with byte_valid low when nothing is sent; tlast marks the last.
// state is updated in the cycle the event is accepted. descriptor bytes come
// out of the descriptor rom; each read is registered into a holding register
// ahead of the output register. results then follow at one byte per cycle
// while the receiver takes them, up to EP0_PACKET_SIZE bytes per event.
// the rom read port sets that rate. a new event is taken once the last read
// of the previous one has moved into the output register.
// a stalled receiver holds the output register and the pending rom read;
// nothing is dropped. reset (rst_n low) returns address, configuration,
// toggles and endpoint flags to their defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder_core
    import ucer_pkg::*;
#(
    parameter int EP0_PACKET_SIZE = 64,
    parameter int ROM_DEPTH       = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // request_type, request_code, request_value, request_index,
    // request_length, suspended, zero pad
    input  logic [71:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // handshake, ep0_toggle, tx_length, data_byte, device_address,
    // configuration_value, ready_flag, endpoint_flags, zero pad
    output logic [47:0] m_axis_tdata,
    // byte_valid
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(ROM_DEPTH);
    localparam int SW = (AW > 9) ? AW + 1 : 10;
    localparam logic [15:0] PKT = 16'(EP0_PACKET_SIZE);

    logic [7:0]  pend_reg, pend_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  romp_reg, romp_next;
    logic [7:0]  cfg_reg, cfg_next;
    logic [6:0]  addr_reg, addr_next;
    logic        tog_reg, tog_next;
    logic        rdy_reg, rdy_next;
    logic [7:0]  epb_reg, epb_next;

    logic [1:0]  ev_hs_reg, ev_hs_next;
    logic [6:0]  ev_len_reg, ev_len_next;
    logic        ev_rom_reg, ev_rom_next;
    logic [7:0]  ev_base_reg, ev_base_next;
    logic [7:0]  ev_pay0_reg, ev_pay0_next;
    logic [6:0]  ev_cnt_reg, ev_cnt_next;

    logic [6:0]  iss_idx_reg, iss_idx_next;
    logic        iss_busy_reg, iss_busy_next;

    logic        q_valid_reg;
    logic [7:0]  q_data_reg;
    logic        q_last_reg;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_bv_reg;
    logic        out_last_reg;

    logic        s_acc;
    logic        advance;
    logic        issue;
    logic        iss_last;
    logic [SW-1:0] rom_sum;
    logic [SW-1:0] rom_wrap;
    logic [AW-1:0] rom_addr;
    logic [7:0]  rom_val;

    cmd_t        cmd;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] rvalue;
    logic [15:0] rindex;
    logic [15:0] rlength;
    logic        rsusp;

    assign cmd     = cmd_t'(s_axis_tuser);
    assign rtype   = s_axis_tdata[7:0];
    assign rcode   = s_axis_tdata[15:8];
    assign rvalue  = s_axis_tdata[31:16];
    assign rindex  = s_axis_tdata[47:32];
    assign rlength = s_axis_tdata[63:48];
    assign rsusp   = s_axis_tdata[64];

    assign s_axis_tready = !iss_busy_reg && !q_valid_reg;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign advance       = q_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue         = iss_busy_reg && (!q_valid_reg || advance);
    assign iss_last      = (iss_idx_reg == ev_cnt_reg - 7'd1);

    // rom address wraps within the rom depth
    assign rom_sum  = SW'(ev_base_reg) + SW'(iss_idx_reg);
    assign rom_wrap = (rom_sum >= SW'(ROM_DEPTH)) ? rom_sum - SW'(ROM_DEPTH) : rom_sum;
    assign rom_addr = rom_wrap[AW-1:0];

    always_comb
    begin
        if (10'(rom_addr) == PKT_SIZE_POS)
        begin
            rom_val = PKT[7:0];
        end
        else
        begin
            rom_val = desc_byte(10'(rom_addr));
        end
    end

    // event decode and state update
    always_comb
    begin
        logic [15:0] rem_v;
        logic [15:0] dlen;
        logic [7:0]  base_v;
        logic        err;
        logic [6:0]  n_v;
        logic        rom_v;
        logic [7:0]  pay0_v;
        logic [1:0]  hs_v;

        pend_next    = pend_reg;
        rem_next     = rem_reg;
        romp_next    = romp_reg;
        cfg_next     = cfg_reg;
        addr_next    = addr_reg;
        tog_next     = tog_reg;
        rdy_next     = rdy_reg;
        epb_next     = epb_reg;
        ev_hs_next   = ev_hs_reg;
        ev_len_next  = ev_len_reg;
        ev_rom_next  = ev_rom_reg;
        ev_base_next = ev_base_reg;
        ev_pay0_next = ev_pay0_reg;
        ev_cnt_next  = ev_cnt_reg;

        rem_v  = rlength;
        dlen   = 16'd0;
        base_v = romp_reg;
        err    = 1'b0;
        n_v    = 7'd0;
        rom_v  = 1'b0;
        pay0_v = 8'd0;
        hs_v   = HS_NOCHANGE;

        if (s_acc)
        begin
            unique case (cmd)
                CMD_SETUP:
                begin
                    tog_next  = 1'b1;
                    pend_next = rcode;
                    if (rtype[6:5] != 2'b00)
                    begin
                        if (rcode != CLS_SET_IDLE && rcode != CLS_SET_REPORT)
                        begin
                            err = 1'b1;
                        end
                    end
                    else
                    begin
                        unique case (rcode)
                            REQ_GET_DESC:
                            begin
                                unique case (rvalue[15:8])
                                    DT_DEVICE:
                                    begin
                                        base_v = OFS_DEV;
                                        dlen   = LEN_DEV;
                                    end
                                    DT_CONFIG:
                                    begin
                                        base_v = OFS_CFG;
                                        dlen   = LEN_CFG;
                                    end
                                    DT_REPORT:
                                    begin
                                        if (rindex[7:0] == 8'd0)
                                        begin
                                            base_v = OFS_KEY;
                                            dlen   = LEN_KEY;
                                        end
                                        else if (rindex[7:0] == 8'd1)
                                        begin
                                            base_v   = OFS_MOUSE;
                                            dlen     = LEN_MOUSE;
                                            rdy_next = 1'b1;
                                        end
                                        else
                                        begin
                                            err = 1'b1;
                                        end
                                    end
                                    DT_STRING:
                                    begin
                                        if (rvalue[7:0] == 8'd0)
                                        begin
                                            base_v = OFS_LANG;
                                            dlen   = LEN_LANG;
                                        end
                                        else if (rvalue[7:0] == 8'd1)
                                        begin
                                            base_v = OFS_MANU;
                                            dlen   = LEN_MANU;
                                        end
                                        else if (rvalue[7:0] == 8'd2)
                                        begin
                                            base_v = OFS_PROD;
                                            dlen   = LEN_PROD;
                                        end
                                        else
                                        begin
                                            err = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                        err = 1'b1;
                                    end
                                endcase
                                if (rem_v > dlen)
                                begin
                                    rem_v = dlen;
                                end
                                n_v       = (rem_v > PKT) ? PKT[6:0] : rem_v[6:0];
                                romp_next = base_v + 8'(n_v);
                                rom_v     = 1'b1;
                            end
                            REQ_SET_ADDRESS:
                            begin
                                rem_v = {8'd0, rvalue[7:0]};
                            end
                            REQ_GET_CONFIG:
                            begin
                                pay0_v = cfg_reg;
                                if (rem_v > 16'd1)
                                begin
                                    rem_v = 16'd1;
                                end
                            end
                            REQ_SET_CONFIG:
                            begin
                                cfg_next = rvalue[7:0];
                            end
                            REQ_CLEAR_FEATURE:
                            begin
                                if (rtype[4:0] == RCPT_ENDPOINT)
                                begin
                                    unique case (rindex[7:0])
                                        EP2_IN:  epb_next = (epb_reg & ~8'h10) | 8'h20;
                                        EP2_OUT: epb_next = (epb_reg & ~8'h40) | 8'h80;
                                        EP1_IN:  epb_next = (epb_reg & ~8'h01) | 8'h02;
                                        EP1_OUT: epb_next = (epb_reg & ~8'h04) | 8'h08;
                                        default: err = 1'b1;
                                    endcase
                                end
                                else
                                begin
                                    err = 1'b1;
                                end
                            end
                            REQ_GET_IFACE:
                            begin
                                if (rem_v > 16'd1)
                                begin
                                    rem_v = 16'd1;
                                end
                            end
                            REQ_GET_STATUS:
                            begin
                                if (rem_v > 16'd2)
                                begin
                                    rem_v = 16'd2;
                                end
                            end
                            default:
                            begin
                                err = 1'b1;
                            end
                        endcase
                    end
                    n_v = 7'd0;
                    if (err)
                    begin
                        hs_v = HS_STALL;
                    end
                    else
                    begin
                        hs_v = HS_ACK;
                        if (rtype[7])
                        begin
                            n_v   = (rem_v > PKT) ? PKT[6:0] : rem_v[6:0];
                            rem_v = rem_v - 16'(n_v);
                        end
                    end
                    rem_next = rem_v;
                end
                CMD_IN_DONE:
                begin
                    if (pend_reg == REQ_GET_DESC)
                    begin
                        n_v       = (rem_reg > PKT) ? PKT[6:0] : rem_reg[6:0];
                        rem_next  = rem_reg - 16'(n_v);
                        romp_next = romp_reg + 8'(n_v);
                        tog_next  = !tog_reg;
                        rom_v     = 1'b1;
                        hs_v      = HS_NOCHANGE;
                    end
                    else
                    begin
                        if (pend_reg == REQ_SET_ADDRESS)
                        begin
                            addr_next = rem_reg[6:0];
                        end
                        tog_next = 1'b0;
                        hs_v     = HS_NAK_TX;
                    end
                end
                CMD_BUS_RST:
                begin
                    addr_next = 7'd0;
                    tog_next  = 1'b0;
                    epb_next  = EPB_RESET;
                    hs_v      = HS_NAK_TX;
                end
                CMD_SUSPEND:
                begin
                    if (rsusp)
                    begin
                        rdy_next = 1'b0;
                    end
                    hs_v = HS_NOCHANGE;
                end
                default:
                begin
                    hs_v = HS_NOCHANGE;
                end
            endcase
            ev_hs_next   = hs_v;
            ev_len_next  = n_v;
            ev_rom_next  = rom_v;
            ev_base_next = base_v;
            ev_pay0_next = pay0_v;
            ev_cnt_next  = (n_v == 7'd0) ? 7'd1 : n_v;
        end
    end

    always_comb
    begin
        iss_idx_next  = iss_idx_reg;
        iss_busy_next = iss_busy_reg;
        if (s_acc)
        begin
            iss_idx_next  = 7'd0;
            iss_busy_next = 1'b1;
        end
        else if (issue)
        begin
            iss_idx_next = iss_idx_reg + 7'd1;
            if (iss_last)
            begin
                iss_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 8'd0;
            rem_reg       <= 16'd0;
            romp_reg      <= 8'd0;
            cfg_reg       <= 8'd0;
            addr_reg      <= 7'd0;
            tog_reg       <= 1'b0;
            rdy_reg       <= 1'b0;
            epb_reg       <= EPB_RESET;
            iss_idx_reg   <= 7'd0;
            iss_busy_reg  <= 1'b0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg     <= pend_next;
            rem_reg      <= rem_next;
            romp_reg     <= romp_next;
            cfg_reg      <= cfg_next;
            addr_reg     <= addr_next;
            tog_reg      <= tog_next;
            rdy_reg      <= rdy_next;
            epb_reg      <= epb_next;
            iss_idx_reg  <= iss_idx_next;
            iss_busy_reg <= iss_busy_next;
            if (issue)
            begin
                q_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                q_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // event context and payload path
    always_ff @(posedge clk)
    begin
        ev_hs_reg   <= ev_hs_next;
        ev_len_reg  <= ev_len_next;
        ev_rom_reg  <= ev_rom_next;
        ev_base_reg <= ev_base_next;
        ev_pay0_reg <= ev_pay0_next;
        ev_cnt_reg  <= ev_cnt_next;
        if (issue)
        begin
            if (ev_rom_reg)
            begin
                q_data_reg <= rom_val;
            end
            else if (iss_idx_reg == 7'd0)
            begin
                q_data_reg <= ev_pay0_reg;
            end
            else
            begin
                q_data_reg <= 8'd0;
            end
            q_last_reg <= iss_last;
        end
        if (advance)
        begin
            out_data_reg <= {6'd0, epb_reg, rdy_reg, cfg_reg, addr_reg,
                             (ev_len_reg != 7'd0) ? q_data_reg : 8'd0,
                             ev_len_reg, tog_reg, ev_hs_reg};
            out_bv_reg   <= (ev_len_reg != 7'd0);
            out_last_reg <= q_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_bv_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### design/ucer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucer_checker
// port level checks for the ep0 responder, bound to the core
// ----------------------------------------------------------------------------
module ucer_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // output transaction is held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped under stall");

    // an accepted event always leaves at least one result to produce
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before results issued");

    // an empty reply is a single transaction
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty reply not marked last");

    // byte_valid agrees with tx_length
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[9:3] == 7'd0) == !m_axis_tuser))
        else $error("byte_valid and tx_length disagree");

endmodule

bind usb_control_endpoint_responder_core ucer_checker u_ucer_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
